FILE: rtl/bta_pkg.sv
// Package: shared constants, codes and controller/datapath bundles of the heap allocator.
`default_nettype none
package bta_pkg;
  localparam int HEAP_BYTES_DEF = 16384;
  localparam int HDR_BYTES = 8;
  localparam int TAG_BYTES = 12;

  localparam logic [2:0] MEM_NONE    = 3'd0;
  localparam logic [2:0] MEM_RD_HDR  = 3'd1;
  localparam logic [2:0] MEM_RD_FLAG = 3'd2;
  localparam logic [2:0] MEM_WR_HDR  = 3'd3;
  localparam logic [2:0] MEM_WR_FLAG = 3'd4;
  localparam logic [2:0] MEM_WR_FTR  = 3'd5;

  localparam logic [2:0] WB_INIT   = 3'd0;
  localparam logic [2:0] WB_ALLOC  = 3'd1;
  localparam logic [2:0] WB_SPLIT  = 3'd2;
  localparam logic [2:0] WB_FREE_A = 3'd3;
  localparam logic [2:0] WB_FREE_N = 3'd4;

  localparam logic [1:0] RES_FAIL  = 2'd0;
  localparam logic [1:0] RES_ALLOC = 2'd1;
  localparam logic [1:0] RES_FREE  = 2'd2;

  typedef struct packed {
    logic [2:0] mem_op;
    logic [2:0] wsel;
    logic       ld_wblk;
    logic       ld_req;
    logic       ld_size;
    logic       ld_flag;
    logic       adv;
    logic       step;
    logic       ld_res;
    logic [1:0] res_sel;
  } cmd_t;

  typedef struct packed {
    logic req_free;
    logic fits_hdr;
    logic blk_fits;
    logic is_free;
    logic is_used;
    logic exact;
    logic bigger;
    logic lt_tgt;
    logic eq_tgt;
  } status_t;
endpackage
`default_nettype wire

FILE: rtl/bta_req_if.sv
// Interfaces: request and response channels of the heap allocator.
`default_nettype none
interface bta_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [14:0] request_bytes;
  logic [31:0] release_address;
  modport source (output valid, req_type, request_bytes, release_address, input ready);
  modport sink (input valid, req_type, request_bytes, release_address, output ready);
endinterface

interface bta_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] payload_address;
  logic        granted;
  modport source (output valid, payload_address, granted, input ready);
  modport sink (input valid, payload_address, granted, output ready);
endinterface
`default_nettype wire

FILE: rtl/boundary_tag_heap_allocator.sv
// Top level: first-fit boundary-tag heap allocator.
// Channels: req (sink) carries allocate or free beats; rsp (source) returns one
// beat per request with payload_address and granted. cfg_we/cfg_data write
// heap_base, which offsets returned addresses; write it only while idle.
// A request walks the block chain from the heap start; each visited block
// takes a header read, a flag read and an evaluate step through the single
// memory port. Grant writes cover header, flag and footer of each block
// written (two blocks on a split). One request is in flight at a time.
// After reset the heap is rewritten as one free block before the
// first request is taken; words outside the block chain are never read.
// A result beat is held in an output register until rsp.ready; the next
// request is accepted meanwhile, and its result waits until the register is
// free.
`default_nettype none
module boundary_tag_heap_allocator import bta_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  bta_req_if.sink          req,
  bta_rsp_if.source        rsp,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);
  cmd_t    cmd;
  status_t sts;

  bta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bta_datapath #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
    .clk             (clk),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .req_type        (req.req_type),
    .request_bytes   (req.request_bytes),
    .release_address (req.release_address),
    .cmd             (cmd),
    .rst             (rst),
    .sts             (sts),
    .payload_address (rsp.payload_address),
    .granted         (rsp.granted)
  );
endmodule
`default_nettype wire

FILE: rtl/bta_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module bta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: rtl/bta_datapath.sv
// Datapath: block walk registers, heap memory, write-block builder and result register.
`default_nettype none
module bta_datapath import bta_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic        req_type,
  input  wire logic [14:0] request_bytes,
  input  wire logic [31:0] release_address,
  input  wire cmd_t        cmd,
  input  wire logic        rst,
  output status_t          sts,
  output logic [31:0]      payload_address,
  output logic             granted
);
  localparam int OW = $clog2(HEAP_BYTES) + 1;
  localparam int WORDS = HEAP_BYTES / 4;
  localparam int WA = $clog2(WORDS);
  localparam logic [OW+1:0] SPAN = (OW+2)'(WORDS * 4);

  logic [31:0]   heap_base;
  logic [OW-1:0] at, prev, wat;
  logic [31:0]   tgt, size, flag, wsize;
  logic [15:0]   need;
  logic          have_prev, prev_open, wflag;

  logic [WA-1:0] ram_addr;
  logic          ram_we;
  logic [31:0]   ram_wdata, ram_rdata;

  logic [OW-1:0] nxt, start, ftr_at;
  logic [33:0]   ext_end;

  assign nxt = at + OW'(TAG_BYTES) + size[OW-1:0];
  assign ext_end = 34'(at) + 34'(TAG_BYTES) + 34'(size);
  assign start = (have_prev && prev_open) ? prev : tgt[OW-1:0];
  assign ftr_at = wat + OW'(HDR_BYTES) + wsize[OW-1:0];

  always_comb begin
    sts.req_free = req_type;
    sts.fits_hdr = ((OW+2)'(at) + (OW+2)'(TAG_BYTES)) <= SPAN;
    sts.blk_fits = ext_end <= 34'(SPAN);
    sts.is_free  = flag == 32'd0;
    sts.is_used  = flag == 32'd1;
    sts.exact    = size == 32'(need);
    sts.bigger   = 33'(size) >= 33'(need) + 33'(TAG_BYTES);
    sts.lt_tgt   = 32'(at) < tgt;
    sts.eq_tgt   = 32'(at) == tgt;
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = wsize;
    ram_addr = at[WA+1:2];
    unique case (cmd.mem_op)
      MEM_RD_HDR:  ram_addr = at[WA+1:2];
      MEM_RD_FLAG: ram_addr = at[WA+1:2] + WA'(1);
      MEM_WR_HDR: begin
        ram_we = 1'b1;
        ram_addr = wat[WA+1:2];
      end
      MEM_WR_FLAG: begin
        ram_we = 1'b1;
        ram_addr = wat[WA+1:2] + WA'(1);
        ram_wdata = {31'd0, wflag};
      end
      MEM_WR_FTR: begin
        ram_we = 1'b1;
        ram_addr = ftr_at[WA+1:2];
      end
      default: ram_we = 1'b0;
    endcase
  end

  bta_ram #(.WIDTH(32), .DEPTH(WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= 32'd0;
    end else if (cfg_we) begin
      heap_base <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      at <= '0;
      have_prev <= 1'b0;
      need <= (16'(request_bytes) + 16'd3) & 16'hFFFC;
      tgt <= release_address - heap_base - 32'(HDR_BYTES);
    end
    if (cmd.ld_size) size <= ram_rdata;
    if (cmd.ld_flag) flag <= ram_rdata;
    if (cmd.adv) begin
      prev <= at;
      prev_open <= flag == 32'd0;
      have_prev <= 1'b1;
      at <= nxt;
    end else if (cmd.step) begin
      at <= nxt;
    end
    if (cmd.ld_wblk) begin
      unique case (cmd.wsel)
        WB_ALLOC: begin
          wat <= at; wsize <= 32'(need); wflag <= 1'b1;
        end
        WB_SPLIT: begin
          wat <= at + OW'(TAG_BYTES) + OW'(need);
          wsize <= size - 32'(need) - 32'(TAG_BYTES); wflag <= 1'b0;
        end
        WB_FREE_A: begin
          wat <= start; wsize <= 32'(at - start - OW'(TAG_BYTES)); wflag <= 1'b0;
        end
        WB_FREE_N: begin
          wat <= start; wsize <= 32'(nxt - start - OW'(TAG_BYTES)); wflag <= 1'b0;
        end
        default: begin
          wat <= '0; wsize <= 32'(SPAN) - 32'(TAG_BYTES); wflag <= 1'b0;
        end
      endcase
    end
    if (cmd.ld_res) begin
      unique case (cmd.res_sel)
        RES_ALLOC: begin
          payload_address <= heap_base + 32'(at) + 32'(HDR_BYTES); granted <= 1'b1;
        end
        RES_FREE: begin
          payload_address <= 32'd0; granted <= 1'b1;
        end
        default: begin
          payload_address <= 32'd0; granted <= 1'b0;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/bta_ctrl.sv
// Controller: sequences the block walk, block writes and the result handshake.
`default_nettype none
module bta_ctrl import bta_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t sts,
  output cmd_t         cmd
);
  localparam logic [3:0] S_BOOT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_RD2  = 4'd4;
  localparam logic [3:0] S_EVAL = 4'd5;
  localparam logic [3:0] S_WH   = 4'd6;
  localparam logic [3:0] S_WF   = 4'd7;
  localparam logic [3:0] S_WT   = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state, state_next;
  logic       booting, booting_next, is_free_op, is_free_op_next;
  logic       tail, tail_next, split, split_next;
  logic [1:0] res, res_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd = '0;
    state_next = state;
    booting_next = booting;
    is_free_op_next = is_free_op;
    tail_next = tail;
    split_next = split;
    res_next = res;
    unique case (state)
      S_BOOT: begin
        cmd.ld_wblk = 1'b1; cmd.wsel = WB_INIT;
        booting_next = 1'b1; split_next = 1'b0;
        state_next = S_WH;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          is_free_op_next = sts.req_free;
          tail_next = 1'b0;
          state_next = S_RD0;
        end
      end
      S_RD0: begin
        if (!sts.fits_hdr) begin
          if (tail) begin
            cmd.ld_wblk = 1'b1; cmd.wsel = WB_FREE_A; split_next = 1'b0;
            res_next = RES_FREE; state_next = S_WH;
          end else begin
            res_next = RES_FAIL; state_next = S_DONE;
          end
        end else begin
          cmd.mem_op = MEM_RD_HDR; state_next = S_RD1;
        end
      end
      S_RD1: begin
        cmd.mem_op = MEM_RD_FLAG; cmd.ld_size = 1'b1; state_next = S_RD2;
      end
      S_RD2: begin
        cmd.ld_flag = 1'b1; state_next = S_EVAL;
      end
      S_EVAL: begin
        if (tail) begin
          cmd.ld_wblk = 1'b1;
          cmd.wsel = (sts.blk_fits && sts.is_free) ? WB_FREE_N : WB_FREE_A;
          split_next = 1'b0; res_next = RES_FREE; state_next = S_WH;
        end else if (!sts.blk_fits) begin
          res_next = RES_FAIL; state_next = S_DONE;
        end else if (!is_free_op) begin
          if (sts.is_free && (sts.exact || sts.bigger)) begin
            cmd.ld_wblk = 1'b1; cmd.wsel = WB_ALLOC;
            split_next = sts.bigger; res_next = RES_ALLOC; state_next = S_WH;
          end else begin
            cmd.step = 1'b1; state_next = S_RD0;
          end
        end else if (sts.lt_tgt) begin
          cmd.adv = 1'b1; state_next = S_RD0;
        end else if (!sts.eq_tgt || !sts.is_used) begin
          res_next = RES_FAIL; state_next = S_DONE;
        end else begin
          cmd.step = 1'b1; tail_next = 1'b1; state_next = S_RD0;
        end
      end
      S_WH: begin
        cmd.mem_op = MEM_WR_HDR; state_next = S_WF;
      end
      S_WF: begin
        cmd.mem_op = MEM_WR_FLAG; state_next = S_WT;
      end
      S_WT: begin
        cmd.mem_op = MEM_WR_FTR;
        if (split) begin
          cmd.ld_wblk = 1'b1; cmd.wsel = WB_SPLIT; split_next = 1'b0;
          state_next = S_WH;
        end else if (booting) begin
          booting_next = 1'b0; state_next = S_IDLE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.ld_res = 1'b1; cmd.res_sel = res; state_next = S_IDLE;
        end
      end
      default: state_next = S_BOOT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BOOT;
      booting <= 1'b1;
      out_valid <= 1'b0;
      split <= 1'b0;
    end else begin
      state <= state_next;
      booting <= booting_next;
      split <= split_next;
      if (cmd.ld_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    is_free_op <= is_free_op_next;
    tail <= tail_next;
    res <= res_next;
  end
endmodule
`default_nettype wire

FILE: rtl/bta_checker.sv
// Checker: port-level properties of the heap allocator, bound to the top level.
`default_nettype none
module bta_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [31:0] payload_address,
  input wire logic        granted
);
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !granted |-> payload_address == 32'd0)
    else $error("failed response with nonzero address");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload_address) && $stable(granted))
    else $error("response beat changed under stall");

  a_no_ready_in_reset: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("ready right after reset");
endmodule

bind boundary_tag_heap_allocator bta_checker u_bta_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .payload_address (rsp.payload_address),
  .granted         (rsp.granted)
);
`default_nettype wire
